>>> sv/mscu_pkg.sv
`default_nettype none
package mscu_pkg;

    localparam int MEM_WORDS_DEF = 256;

    localparam logic [5:0] OP_RTYPE = 6'h00;
    localparam logic [5:0] OP_J     = 6'h02;
    localparam logic [5:0] OP_BEQ   = 6'h04;
    localparam logic [5:0] OP_ADDI  = 6'h08;
    localparam logic [5:0] OP_LW    = 6'h23;
    localparam logic [5:0] OP_SW    = 6'h2B;

    localparam logic [5:0] FN_ADD = 6'h20;
    localparam logic [5:0] FN_SUB = 6'h22;
    localparam logic [5:0] FN_AND = 6'h24;
    localparam logic [5:0] FN_OR  = 6'h25;
    localparam logic [5:0] FN_SLT = 6'h2A;

    localparam logic [5:0]  FIELD_MASK  = 6'h3F;
    localparam logic [25:0] TARGET_MASK = 26'h3FFFFFF;

    localparam logic OPER_LOAD = 1'b0;
    localparam logic OPER_STEP = 1'b1;

    typedef enum logic [2:0] {
        STAT_OK     = 3'd0,
        STAT_FETCH  = 3'd1,
        STAT_FUNCT  = 3'd2,
        STAT_OPCODE = 3'd3,
        STAT_LOAD   = 3'd4,
        STAT_STORE  = 3'd5,
        STAT_HALTED = 3'd6
    } status_t;

    typedef struct packed {
        logic        operation;
        logic [7:0]  word_index;
        logic [31:0] word_data;
    } in_beat_t;

    typedef struct packed {
        logic [31:0]        pc_value;
        logic               halted;
        logic [2:0]         status;
        logic               reg_written;
        logic [4:0]         reg_index;
        logic signed [31:0] reg_value;
        logic               mem_written;
        logic [31:0]        mem_address;
        logic [31:0]        mem_value;
        logic [31:0]        step_count;
    } out_beat_t;

    typedef struct packed {
        status_t     status;
        logic        reg_we;
        logic [4:0]  reg_idx;
        logic [31:0] reg_val;
        logic        mem_rd;
        logic        mem_we;
        logic [31:0] mem_ea;
        logic [31:0] mem_val;
        logic [31:0] next_pc;
    } exec_res_t;

    function automatic logic addr_ok(input logic [31:0] addr, input int words);
        return (addr[1:0] == 2'b00) && ({2'b00, addr[31:2]} < 32'(words));
    endfunction

endpackage
`default_nettype wire

>>> sv/mscu_word_mem.sv
`default_nettype none
module mscu_word_mem #(
    parameter int WORDS = mscu_pkg::MEM_WORDS_DEF,
    parameter int AW    = $clog2(WORDS)
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [31:0]   wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [31:0]   rdata,
    output logic               busy
);

    logic [31:0]   mem [WORDS];
    logic [AW-1:0] clr_idx_reg;
    logic          busy_reg;
    logic [31:0]   rdata_reg;

    // sweep every word to zero once after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_idx_reg <= '0;
            busy_reg    <= 1'b1;
        end else if (busy_reg) begin
            if (clr_idx_reg == AW'(WORDS - 1)) begin
                busy_reg <= 1'b0;
            end else begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            mem[clr_idx_reg] <= '0;
        end else if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
    assign busy  = busy_reg;

endmodule
`default_nettype wire

>>> sv/mscu_reg_file.sv
`default_nettype none
module mscu_reg_file (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        re,
    input  wire logic [4:0]  ra_idx,
    input  wire logic [4:0]  rb_idx,
    input  wire logic        we,
    input  wire logic [4:0]  w_idx,
    input  wire logic [31:0] w_data,
    output logic      [31:0] ra_data,
    output logic      [31:0] rb_data
);

    logic [31:0] mem [32];
    logic [31:0] vld_reg;
    logic [31:0] ra_q_reg;
    logic [31:0] rb_q_reg;
    logic        ra_ok_reg;
    logic        rb_ok_reg;

    // valid bits stand in for the reset clear; register zero never reads valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg   <= '0;
            ra_ok_reg <= 1'b0;
            rb_ok_reg <= 1'b0;
        end else begin
            if (we && (w_idx != 5'd0)) begin
                vld_reg[w_idx] <= 1'b1;
            end
            if (re) begin
                ra_ok_reg <= vld_reg[ra_idx] && (ra_idx != 5'd0);
                rb_ok_reg <= vld_reg[rb_idx] && (rb_idx != 5'd0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[w_idx] <= w_data;
        end
        if (re) begin
            ra_q_reg <= mem[ra_idx];
            rb_q_reg <= mem[rb_idx];
        end
    end

    assign ra_data = ra_ok_reg ? ra_q_reg : '0;
    assign rb_data = rb_ok_reg ? rb_q_reg : '0;

endmodule
`default_nettype wire

>>> sv/mscu_exec.sv
`default_nettype none
module mscu_exec #(
    parameter int MEM_WORDS = mscu_pkg::MEM_WORDS_DEF
) (
    input  wire logic [31:0]        ins,
    input  wire logic [31:0]        a,
    input  wire logic [31:0]        b,
    input  wire logic [31:0]        pc,
    output mscu_pkg::exec_res_t     res
);

    logic [5:0]  op;
    logic [5:0]  fn;
    logic [31:0] imm;
    logic [31:0] pc4;
    logic [31:0] ea;
    logic        ea_ok;

    assign op    = (ins[31:26]) & mscu_pkg::FIELD_MASK;
    assign fn    = ins[5:0] & mscu_pkg::FIELD_MASK;
    assign imm   = {{16{ins[15]}}, ins[15:0]};
    assign pc4   = pc + 32'd4;
    assign ea    = a + imm;
    assign ea_ok = mscu_pkg::addr_ok(ea, MEM_WORDS);

    always_comb begin
        res         = '0;
        res.status  = mscu_pkg::STAT_OK;
        res.next_pc = pc4;
        case (op)
            mscu_pkg::OP_RTYPE: begin
                res.reg_we  = 1'b1;
                res.reg_idx = ins[15:11];
                case (fn)
                    mscu_pkg::FN_ADD: res.reg_val = a + b;
                    mscu_pkg::FN_SUB: res.reg_val = a - b;
                    mscu_pkg::FN_AND: res.reg_val = a & b;
                    mscu_pkg::FN_OR:  res.reg_val = a | b;
                    mscu_pkg::FN_SLT: res.reg_val = {31'd0, $signed(a) < $signed(b)};
                    default:          res.status  = mscu_pkg::STAT_FUNCT;
                endcase
            end
            mscu_pkg::OP_J: begin
                res.next_pc = {pc4[31:28], ins[25:0] & mscu_pkg::TARGET_MASK, 2'b00};
            end
            mscu_pkg::OP_ADDI: begin
                res.reg_we  = 1'b1;
                res.reg_idx = ins[20:16];
                res.reg_val = ea;
            end
            mscu_pkg::OP_LW: begin
                if (ea_ok) begin
                    res.reg_we  = 1'b1;
                    res.reg_idx = ins[20:16];
                    res.mem_rd  = 1'b1;
                    res.mem_ea  = ea;
                end else begin
                    res.status = mscu_pkg::STAT_LOAD;
                end
            end
            mscu_pkg::OP_SW: begin
                if (ea_ok) begin
                    res.mem_we  = 1'b1;
                    res.mem_ea  = ea;
                    res.mem_val = b;
                end else begin
                    res.status = mscu_pkg::STAT_STORE;
                end
            end
            mscu_pkg::OP_BEQ: begin
                if (a == b) begin
                    res.next_pc = pc4 + {imm[29:0], 2'b00};
                end
            end
            default: res.status = mscu_pkg::STAT_OPCODE;
        endcase

        // drop every side effect on a fault; writes to register zero vanish
        if (res.status != mscu_pkg::STAT_OK) begin
            res.reg_we  = 1'b0;
            res.reg_idx = '0;
            res.reg_val = '0;
            res.mem_rd  = 1'b0;
            res.mem_we  = 1'b0;
            res.mem_ea  = '0;
            res.mem_val = '0;
            res.next_pc = pc;
        end else if (res.reg_we && (res.reg_idx == 5'd0)) begin
            res.reg_we  = 1'b0;
            res.reg_val = '0;
            res.mem_rd  = 1'b0;
            res.mem_ea  = '0;
        end
    end

endmodule
`default_nettype wire

>>> sv/mips_subset_core_unit.sv
// A load beat, a step on a halted core or a step that faults on fetch is answered straight
// from IDLE with a registered result; any other step walks FETCH and EXEC (and LOAD for lw:
// the data word comes back from the word memory after the EXEC read).
// The input buffer can take the next beat while one is in flight, but the sequencer handles
// one at a time, paced by the fetch read, the register-file read and the data access on the
// synchronous memories. Reset (aresetn low, synchronous) zeroes PC, halt and step count,
// invalidates the register file, then clears the word memory with s_ready low.
`default_nettype none
module mips_subset_core_unit #(
    parameter int MEM_WORDS = mscu_pkg::MEM_WORDS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire mscu_pkg::in_beat_t  s_payload,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output mscu_pkg::out_beat_t      m_payload
);

    localparam int AW = $clog2(MEM_WORDS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC,
        S_LOAD
    } state_t;

    state_t              state_reg;
    logic                inbuf_valid_reg;
    mscu_pkg::in_beat_t  inbuf_reg;
    logic [31:0]         pc_reg;
    logic                halt_reg;
    logic [31:0]         steps_reg;
    logic [31:0]         ins_reg;
    logic                m_valid_reg;
    mscu_pkg::out_beat_t m_payload_reg;

    state_t              state_next;
    logic                inbuf_valid_next;
    mscu_pkg::in_beat_t  inbuf_next;
    logic [31:0]         pc_next;
    logic                halt_next;
    logic [31:0]         steps_next;
    logic [31:0]         ins_next;
    logic                m_valid_next;
    mscu_pkg::out_beat_t m_payload_next;

    logic                mem_busy;
    logic [31:0]         mem_rdata;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [31:0]         mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;

    logic                rf_re;
    logic                rf_we;
    logic [31:0]         rf_wdata;
    logic [31:0]         rf_a;
    logic [31:0]         rf_b;

    mscu_pkg::exec_res_t ex;
    logic                start;
    logic                idx_ok;
    logic                pc_ok;
    logic [31:0]         ins_cur;

    // the input buffer decouples acceptance from the sequencer
    assign s_ready = !inbuf_valid_reg && !mem_busy;
    assign start   = (state_reg == S_IDLE) && inbuf_valid_reg && (!m_valid_reg || m_ready);
    assign idx_ok  = {24'd0, inbuf_reg.word_index} < 32'(MEM_WORDS);
    assign pc_ok   = mscu_pkg::addr_ok(pc_reg, MEM_WORDS);

    // the fetched word is live on the memory output in FETCH, held after that
    assign ins_cur = (state_reg == S_FETCH) ? mem_rdata : ins_reg;

    mscu_word_mem #(
        .WORDS (MEM_WORDS),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .re      (mem_re),
        .raddr   (mem_raddr),
        .rdata   (mem_rdata),
        .busy    (mem_busy)
    );

    mscu_reg_file u_rf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .re      (rf_re),
        .ra_idx  (ins_cur[25:21]),
        .rb_idx  (ins_cur[20:16]),
        .we      (rf_we),
        .w_idx   (ex.reg_idx),
        .w_data  (rf_wdata),
        .ra_data (rf_a),
        .rb_data (rf_b)
    );

    mscu_exec #(
        .MEM_WORDS (MEM_WORDS)
    ) u_exec (
        .ins (ins_reg),
        .a   (rf_a),
        .b   (rf_b),
        .pc  (pc_reg),
        .res (ex)
    );

    // memory ports: load beats write at the start, sw writes in EXEC
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = AW'(inbuf_reg.word_index);
        mem_wdata = inbuf_reg.word_data;
        mem_re    = 1'b0;
        mem_raddr = AW'(pc_reg[31:2]);
        if (start && (inbuf_reg.operation == mscu_pkg::OPER_LOAD)) begin
            mem_we = idx_ok;
        end else if (start && !halt_reg && pc_ok) begin
            mem_re = 1'b1;
        end
        if (state_reg == S_EXEC) begin
            if (ex.mem_we) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(ex.mem_ea[31:2]);
                mem_wdata = ex.mem_val;
            end
            if (ex.mem_rd) begin
                mem_re    = 1'b1;
                mem_raddr = AW'(ex.mem_ea[31:2]);
            end
        end
    end

    assign rf_re    = (state_reg == S_FETCH);
    assign rf_we    = ((state_reg == S_EXEC) && ex.reg_we && !ex.mem_rd) ||
                      (state_reg == S_LOAD);
    assign rf_wdata = (state_reg == S_LOAD) ? mem_rdata : ex.reg_val;

    always_comb begin
        state_next       = state_reg;
        inbuf_valid_next = inbuf_valid_reg;
        inbuf_next       = inbuf_reg;
        pc_next          = pc_reg;
        halt_next        = halt_reg;
        steps_next       = steps_reg;
        ins_next         = ins_reg;
        m_valid_next     = m_valid_reg;
        m_payload_next   = m_payload_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            inbuf_valid_next = 1'b1;
            inbuf_next       = s_payload;
        end
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    inbuf_valid_next          = 1'b0;
                    m_payload_next            = '0;
                    m_payload_next.pc_value   = pc_reg;
                    m_payload_next.halted     = halt_reg;
                    m_payload_next.step_count = steps_reg;
                    m_payload_next.status     = mscu_pkg::STAT_OK;
                    if (inbuf_reg.operation == mscu_pkg::OPER_LOAD) begin
                        m_valid_next = 1'b1;
                    end else if (halt_reg) begin
                        m_payload_next.status = mscu_pkg::STAT_HALTED;
                        m_valid_next          = 1'b1;
                    end else if (!pc_ok) begin
                        // fetch fault: halt, PC and step count hold
                        halt_next             = 1'b1;
                        m_payload_next.halted = 1'b1;
                        m_payload_next.status = mscu_pkg::STAT_FETCH;
                        m_valid_next          = 1'b1;
                    end else begin
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                ins_next   = mem_rdata;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                steps_next                 = steps_reg + 32'd1;
                pc_next                    = ex.next_pc;
                m_payload_next.pc_value    = ex.next_pc;
                m_payload_next.step_count  = steps_reg + 32'd1;
                m_payload_next.status      = ex.status;
                m_payload_next.reg_written = ex.reg_we;
                m_payload_next.reg_index   = ex.reg_idx;
                m_payload_next.reg_value   = ex.reg_val;
                m_payload_next.mem_written = ex.mem_we;
                m_payload_next.mem_address = ex.mem_we ? ex.mem_ea : 32'd0;
                m_payload_next.mem_value   = ex.mem_val;
                if (ex.status != mscu_pkg::STAT_OK) begin
                    halt_next             = 1'b1;
                    m_payload_next.halted = 1'b1;
                end
                if (ex.mem_rd) begin
                    state_next = S_LOAD;
                end else begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_LOAD: begin
                // lw data arrives in the cycle after the EXEC read
                m_payload_next.reg_value = mem_rdata;
                m_valid_next             = 1'b1;
                state_next               = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            inbuf_valid_reg <= 1'b0;
            inbuf_reg       <= '0;
            pc_reg          <= '0;
            halt_reg        <= 1'b0;
            steps_reg       <= '0;
            ins_reg         <= '0;
            m_valid_reg     <= 1'b0;
            m_payload_reg   <= '0;
        end else begin
            state_reg       <= state_next;
            inbuf_valid_reg <= inbuf_valid_next;
            inbuf_reg       <= inbuf_next;
            pc_reg          <= pc_next;
            halt_reg        <= halt_next;
            steps_reg       <= steps_next;
            ins_reg         <= ins_next;
            m_valid_reg     <= m_valid_next;
            m_payload_reg   <= m_payload_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // the clearing sweep never overlaps an instruction in flight
    a_busy_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_busy |-> (state_reg == S_IDLE) && !inbuf_valid_reg)
        else $error("word memory clear overlaps execution");

    // halt is sticky until reset
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halt_reg |=> halt_reg)
        else $error("halt flag dropped");

    // the step count only advances at the execute stage
    a_steps_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_EXEC) |=> $stable(steps_reg))
        else $error("step count moved outside execute");

    // a step while halted reports the halted status at once
    a_halted_step: assert property (@(posedge aclk) disable iff (!aresetn)
        start && halt_reg && (inbuf_reg.operation == mscu_pkg::OPER_STEP) |=>
        m_valid_reg && (m_payload_reg.status == mscu_pkg::STAT_HALTED))
        else $error("halted step not reported");

endmodule
`default_nettype wire
